// ===== design/leaky_incremental_pid_balance_assert.svh =====
// Assertion macros for the leaky incremental PID balance controller.
`ifndef LEAKY_INCREMENTAL_PID_BALANCE_ASSERT_SVH
`define LEAKY_INCREMENTAL_PID_BALANCE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LIPB_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LIPB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lipb_pkg.sv =====
// Shared constants, types and control store for the balance controller.
package lipb_pkg;

  localparam int SENSOR_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 10;

  localparam int COEF_W  = 16;
  localparam int DECAY_W = 11;
  localparam int BIAS_W  = 12;
  localparam int BAND_W  = 10;
  localparam int DIV_W   = 5;
  localparam int ACC_W   = 40;
  localparam int SPEED_W = 11;
  localparam int SERVO_W = 10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = ((2 * SPEED_W + SERVO_W + 7) / 8) * 8;

  localparam int SPEED_LIMIT = 1023;
  localparam logic [SERVO_W-1:0] SERVO_CENTER = SERVO_W'(512);
  localparam logic [DIV_W-1:0]   DIV_MIN      = DIV_W'(2);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DECAY     = 3'd3,
    REG_BIAS      = 3'd4,
    REG_DEADBAND  = 3'd5,
    REG_ANGLE_DIV = 3'd6
  } reg_idx_t;

  localparam logic [COEF_W-1:0]  RST_GAIN_P    = COEF_W'(10752);
  localparam logic [COEF_W-1:0]  RST_GAIN_I    = COEF_W'(92);
  localparam logic [COEF_W-1:0]  RST_GAIN_D    = COEF_W'(492);
  localparam logic [DECAY_W-1:0] RST_DECAY     = DECAY_W'(973);
  localparam logic [BIAS_W-1:0]  RST_BIAS      = 12'hFEC;
  localparam logic [BAND_W-1:0]  RST_DEADBAND  = BAND_W'(10);
  localparam logic [DIV_W-1:0]   RST_ANGLE_DIV = DIV_W'(4);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SETUP_I,
    OP_MUL,
    OP_ADD_I,
    OP_ADD_D,
    OP_PTERM,
    OP_ACC,
    OP_OUTP,
    OP_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_IN,
    JC_MUL,
    JC_DIV,
    JC_OUT
  } jc_t;

  typedef struct packed {
    op_t  op;
    jc_t  jc;
    logic last;
  } ucode_t;

  localparam int PC_W = 4;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{OP_LOAD,    JC_IN,   1'b0};
      4'd1:    w = '{OP_SETUP_I, JC_NEXT, 1'b0};
      4'd2:    w = '{OP_MUL,     JC_MUL,  1'b0};
      4'd3:    w = '{OP_ADD_I,   JC_NEXT, 1'b0};
      4'd4:    w = '{OP_MUL,     JC_MUL,  1'b0};
      4'd5:    w = '{OP_ADD_D,   JC_NEXT, 1'b0};
      4'd6:    w = '{OP_MUL,     JC_MUL,  1'b0};
      4'd7:    w = '{OP_PTERM,   JC_NEXT, 1'b0};
      4'd8:    w = '{OP_MUL,     JC_MUL,  1'b0};
      4'd9:    w = '{OP_ACC,     JC_NEXT, 1'b0};
      4'd10:   w = '{OP_OUTP,    JC_NEXT, 1'b0};
      4'd11:   w = '{OP_DIV,     JC_DIV,  1'b0};
      4'd12:   w = '{OP_EMIT,    JC_OUT,  1'b1};
      default: w = '{OP_NOP,     JC_NEXT, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== design/leaky_incremental_pid_balance.sv =====
// Leaky incremental PID balance controller: one sensor pair in, one drive result out.
//
// One sample pair is taken at a time. A short control program in a read-only store steps
// a shared shift-add multiplier through four products (integral weight, derivative weight,
// loop gain, leak factor), then a restoring divider forms the servo offset. The multiplier
// retires one coefficient bit per cycle. The result sits in an output register, so the
// next sample is taken while it waits for out_tready.

`include "leaky_incremental_pid_balance_assert.svh"

module leaky_incremental_pid_balance #(
  parameter int SENSOR_BITS = lipb_pkg::SENSOR_BITS_DEF,
  parameter int FRAC_BITS   = lipb_pkg::FRAC_BITS_DEF,
  localparam int IN_DATA_W  = ((2 * SENSOR_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lipb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lipb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_DATA_W-1:0]              in_tdata,   // sensor_left, sensor_right
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lipb_pkg::OUT_DATA_W-1:0]   out_tdata,  // speed_left, speed_right, servo_position
  output logic                              out_tuser   // in_deadband
);
  import lipb_pkg::*;

  localparam int ERR_W   = ((SENSOR_BITS > BIAS_W) ? SENSOR_BITS : BIAS_W) + 2;
  localparam int D1_W    = ERR_W + 1;
  localparam int D2_W    = ERR_W + 2;
  localparam int INNER_W = ERR_W + ((FRAC_BITS > COEF_W) ? FRAC_BITS : COEF_W) + 4;
  localparam int DP_A    = INNER_W + COEF_W + 1;
  localparam int DP_B    = ACC_W + DECAY_W + 1;
  localparam int DP_W    = (DP_A > DP_B) ? DP_A : DP_B;
  localparam int NUM_W   = DIV_W + SERVO_W + 1;
  localparam int CNT_W   = $clog2(SERVO_W + 1);

  localparam logic signed [DP_W-1:0] ACC_HI =
    {{(DP_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [DP_W-1:0] ACC_LO =
    {{(DP_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(SPEED_LIMIT) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] CLAMP_LO = -CLAMP_HI;

  logic [COEF_W-1:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [DECAY_W-1:0]       decay_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic [BAND_W-1:0]        deadband_r;
  logic [DIV_W-1:0]         angle_div_r;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uc;
  logic            stay;
  logic            in_fire;

  logic signed [ERR_W-1:0] err_r, err_nxt, e1_r, e1_nxt, e2_r, e2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [DP_W-1:0]  sum_r, sum_nxt, p_r, p_nxt, m_r, m_nxt;
  logic [COEF_W-1:0]       q_r, q_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;
  logic                    dead_r, dead_nxt;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic signed [SPEED_W-1:0] out_speed_r, out_speed_nxt;
  logic [SERVO_W-1:0]        out_servo_r, out_servo_nxt;
  logic                      out_dead_r, out_dead_nxt;

  logic [SENSOR_BITS-1:0]    in_left, in_right;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [D1_W-1:0]    d1;
  logic signed [D2_W-1:0]    d2;
  logic signed [DP_W-1:0]    sum_c;
  logic signed [ACC_W-1:0]   band_c, clamp_c, mag_c;
  logic                      dead_c;
  logic [SPEED_W-1:0]        spd_mag_c;
  logic signed [SPEED_W-1:0] speed_c, cf_c;
  logic [DIV_W-1:0]          div_eff;
  logic signed [NUM_W-1:0]   num_c;

  assign uc        = ucode_rom(pc_r);
  assign in_tready = (uc.op == OP_LOAD);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_dead_r;
  assign out_tdata  = OUT_DATA_W'({out_servo_r, SPEED_W'(-out_speed_r), out_speed_r});

  assign in_left  = in_tdata[SENSOR_BITS-1:0];
  assign in_right = in_tdata[2*SENSOR_BITS-1:SENSOR_BITS];
  assign err_in   = $signed(ERR_W'(in_left)) - $signed(ERR_W'(in_right)) - ERR_W'(bias_r);

  assign d1    = D1_W'(err_r) - D1_W'(e1_r);
  assign d2    = D2_W'(err_r) - (D2_W'(e1_r) <<< 1) + D2_W'(e2_r);
  assign sum_c = sum_r + (p_r >>> FRAC_BITS);

  assign band_c  = $signed(ACC_W'({deadband_r, {FRAC_BITS{1'b0}}}));
  assign dead_c  = (acc_r >= -band_c) && (acc_r <= band_c);
  assign clamp_c = (acc_r > CLAMP_HI) ? CLAMP_HI : ((acc_r < CLAMP_LO) ? CLAMP_LO : acc_r);
  assign mag_c   = clamp_c[ACC_W-1] ? -clamp_c : clamp_c;
  assign spd_mag_c = SPEED_W'(mag_c >> FRAC_BITS);
  assign speed_c = clamp_c[ACC_W-1] ? -$signed(spd_mag_c) : $signed(spd_mag_c);
  assign cf_c    = $signed(clamp_c[FRAC_BITS+SPEED_W-1:FRAC_BITS]);
  assign div_eff = (angle_div_r < DIV_MIN) ? DIV_MIN : angle_div_r;
  assign num_c   = $signed({2'b00, div_eff, {(SERVO_W - 1){1'b0}}}) + NUM_W'(cf_c);

  always_comb begin
    unique case (uc.jc)
      JC_NEXT: stay = 1'b0;
      JC_IN:   stay = !in_fire;
      JC_MUL:  stay = |q_r[COEF_W-1:1];
      JC_DIV:  stay = (cnt_r != CNT_W'(1));
      JC_OUT:  stay = out_tvalid_r && !out_tready;
      default: stay = 1'b0;
    endcase
    if (stay) begin
      pc_nxt = pc_r;
    end else if (uc.last) begin
      pc_nxt = '0;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_comb begin
    err_nxt   = err_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    speed_nxt = speed_r;
    dead_nxt  = dead_r;
    out_speed_nxt  = out_speed_r;
    out_servo_nxt  = out_servo_r;
    out_dead_nxt   = out_dead_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (uc.op)
      OP_LOAD: begin
        if (in_fire) begin
          err_nxt = err_in;
        end
      end
      OP_SETUP_I: begin
        sum_nxt = DP_W'(d1) <<< FRAC_BITS;
        m_nxt   = DP_W'(err_r);
        q_nxt   = gain_i_r;
        p_nxt   = '0;
      end
      OP_MUL: begin
        p_nxt = q_r[0] ? p_r + m_r : p_r;
        m_nxt = m_r <<< 1;
        q_nxt = q_r >> 1;
      end
      OP_ADD_I: begin
        sum_nxt = sum_r + p_r;
        m_nxt   = DP_W'(d2);
        q_nxt   = gain_d_r;
        p_nxt   = '0;
      end
      OP_ADD_D: begin
        m_nxt = sum_r + p_r;
        q_nxt = gain_p_r;
        p_nxt = '0;
      end
      OP_PTERM: begin
        sum_nxt = p_r >>> FRAC_BITS;
        m_nxt   = DP_W'(acc_r);
        q_nxt   = COEF_W'(decay_r);
        p_nxt   = '0;
      end
      OP_ACC: begin
        if (sum_c > ACC_HI) begin
          acc_nxt = ACC_W'(ACC_HI);
        end else if (sum_c < ACC_LO) begin
          acc_nxt = ACC_W'(ACC_LO);
        end else begin
          acc_nxt = ACC_W'(sum_c);
        end
        e2_nxt = e1_r;
        e1_nxt = err_r;
      end
      OP_OUTP: begin
        dead_nxt  = dead_c;
        speed_nxt = dead_c ? '0 : speed_c;
        p_nxt     = DP_W'(num_c);
        m_nxt     = $signed(DP_W'(div_eff)) <<< (SERVO_W - 1);
        q_nxt     = '0;
        cnt_nxt   = CNT_W'(SERVO_W);
      end
      OP_DIV: begin
        if (p_r >= m_r) begin
          p_nxt = p_r - m_r;
          q_nxt = {q_r[COEF_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_r[COEF_W-2:0], 1'b0};
        end
        m_nxt   = m_r >>> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_EMIT: begin
        if (!stay) begin
          out_speed_nxt  = speed_r;
          out_servo_nxt  = dead_r ? SERVO_CENTER : q_r[SERVO_W-1:0];
          out_dead_nxt   = dead_r;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= '0;
      out_tvalid_r <= 1'b0;
      e1_r         <= '0;
      e2_r         <= '0;
      acc_r        <= '0;
    end else begin
      pc_r         <= pc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      e1_r         <= e1_nxt;
      e2_r         <= e2_nxt;
      acc_r        <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= RST_GAIN_P;
      gain_i_r    <= RST_GAIN_I;
      gain_d_r    <= RST_GAIN_D;
      decay_r     <= RST_DECAY;
      bias_r      <= $signed(RST_BIAS);
      deadband_r  <= RST_DEADBAND;
      angle_div_r <= RST_ANGLE_DIV;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_GAIN_P:    gain_p_r    <= cfg_wdata;
        REG_GAIN_I:    gain_i_r    <= cfg_wdata;
        REG_GAIN_D:    gain_d_r    <= cfg_wdata;
        REG_DECAY:     decay_r     <= cfg_wdata[DECAY_W-1:0];
        REG_BIAS:      bias_r      <= $signed(cfg_wdata[BIAS_W-1:0]);
        REG_DEADBAND:  deadband_r  <= cfg_wdata[BAND_W-1:0];
        REG_ANGLE_DIV: angle_div_r <= cfg_wdata[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    sum_r       <= sum_nxt;
    p_r         <= p_nxt;
    m_r         <= m_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    speed_r     <= speed_nxt;
    dead_r      <= dead_nxt;
    out_speed_r <= out_speed_nxt;
    out_servo_r <= out_servo_nxt;
    out_dead_r  <= out_dead_nxt;
  end

  `LIPB_ASSERT_NEXT(a_accept_starts_program, in_tvalid && in_tready, uc.op == OP_SETUP_I, "accepted beat did not start the program")
  `LIPB_ASSERT_SAME(a_result_from_emit, $rose(out_tvalid), $past(uc.op == OP_EMIT), "result raised outside the emit step")
  `LIPB_ASSERT_SAME(a_deadband_centers, out_tvalid && out_tuser, (out_tdata[31:22] == SERVO_CENTER) && (out_tdata[10:0] == '0), "deadband beat not centered")
  `LIPB_ASSERT_SAME(a_speeds_mirror, out_tvalid, out_tdata[21:11] == SPEED_W'(-out_tdata[10:0]), "right speed is not the negated left speed")

endmodule

// ===== tb/leaky_incremental_pid_balance_tb.sv =====
// Self-checking testbench for the leaky incremental PID balance controller.
`timescale 1ns / 1ps

module leaky_incremental_pid_balance_tb;
  import lipb_pkg::*;

  localparam int IN_W = ((2 * SENSOR_BITS_DEF + 7) / 8) * 8;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic               dead;
    logic [SERVO_W-1:0] servo;
    logic [SPEED_W-1:0] speed_right;
    logic [SPEED_W-1:0] speed_left;
  } drive_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] value;
    logic [11:0]           left;
    logic [11:0]           right;
    logic                  typed;
    drive_t                want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  leaky_incremental_pid_balance u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // controller mirror
  logic [COEF_W-1:0]  gain_p_q = RST_GAIN_P;
  logic [COEF_W-1:0]  gain_i_q = RST_GAIN_I;
  logic [COEF_W-1:0]  gain_d_q = RST_GAIN_D;
  logic [DECAY_W-1:0] decay_q  = RST_DECAY;
  logic [BIAS_W-1:0]  bias_q   = RST_BIAS;
  logic [BAND_W-1:0]  band_q   = RST_DEADBAND;
  logic [DIV_W-1:0]   div_q    = RST_ANGLE_DIV;
  longint err_prev  = 0;
  longint err_prev2 = 0;
  longint acc_q     = 0;

  drive_t      pending_drives[$];
  step_row_t   plan[$];
  drive_t      got;
  drive_t      want;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;
  logic [11:0] last_left = '0;
  logic [11:0] last_right = '0;
  logic [11:0] pick_l;
  logic [11:0] pick_r;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic drive_t predict_drive(input logic [11:0] left, input logic [11:0] right);
    longint err;
    longint inner;
    longint sum;
    longint band;
    longint lim;
    longint c;
    longint dv;
    longint speed;
    longint servo;
    drive_t d;
    err = longint'(left) - longint'(right) - longint'($signed(bias_q));
    inner = (err - err_prev) * ONE + longint'(gain_i_q) * err
          + longint'(gain_d_q) * (err - 2 * err_prev + err_prev2);
    sum = ((longint'(gain_p_q) * inner) >>> FRAC) + ((longint'(decay_q) * acc_q) >>> FRAC);
    if (sum > ACC_HI) sum = ACC_HI;
    else if (sum < ACC_LO) sum = ACC_LO;
    acc_q = sum;
    err_prev2 = err_prev;
    err_prev = err;
    band = longint'(band_q) * ONE;
    d = '0;
    if (sum >= -band && sum <= band) begin
      d.dead = 1'b1;
      d.servo = SERVO_CENTER;
    end else begin
      lim = longint'(SPEED_LIMIT) * ONE;
      c = sum;
      if (c > lim) c = lim;
      if (c < -lim) c = -lim;
      speed = (c >= 0) ? (c >>> FRAC) : -((-c) >>> FRAC);
      dv = (div_q < DIV_MIN) ? longint'(DIV_MIN) : longint'(div_q);
      servo = ((longint'(SERVO_CENTER) * dv * ONE + c) >>> FRAC) / dv;
      if (servo < 0) servo = 0;
      if (servo > 1023) servo = 1023;
      d.speed_left = SPEED_W'(speed);
      d.speed_right = SPEED_W'(-speed);
      d.servo = SERVO_W'(servo);
    end
    return d;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (calm || k < 60) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input reg_idx_t idx);
    logic [CFG_DATA_W-1:0] v;
    int unsigned k;
    v = CFG_DATA_W'($urandom);
    k = $urandom_range(0, 4);
    case (idx)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
        if (k == 0) v = '0;
        else if (k == 1) v = '1;
        else if (k == 2) v = CFG_DATA_W'($urandom_range(0, 2047));
      end
      REG_DECAY: begin
        if (k == 0) v[DECAY_W-1:0] = '0;
        else if (k == 1) v[DECAY_W-1:0] = DECAY_W'(1024);
        else if (k == 2) v[DECAY_W-1:0] = '1;
        else v[DECAY_W-1:0] = DECAY_W'($urandom_range(800, 1024));
      end
      REG_BIAS: begin
        if (k == 0) v[BIAS_W-1:0] = 12'h800;
        else if (k == 1) v[BIAS_W-1:0] = 12'h7FF;
        else if (k == 2) v[BIAS_W-1:0] = BIAS_W'($urandom_range(0, 64)) - BIAS_W'(32);
      end
      REG_DEADBAND: begin
        if (k == 0) v[BAND_W-1:0] = '0;
        else if (k == 1) v[BAND_W-1:0] = '1;
        else v[BAND_W-1:0] = BAND_W'($urandom_range(0, 40));
      end
      REG_ANGLE_DIV: begin
        if (k == 0) v[DIV_W-1:0] = DIV_W'($urandom_range(0, 1));
        else if (k == 1) v[DIV_W-1:0] = DIV_W'(16);
        else if (k == 2) v[DIV_W-1:0] = '1;
        else v[DIV_W-1:0] = DIV_W'($urandom_range(2, 16));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic step_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] value);
    step_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.addr = addr;
    s.value = value;
    return s;
  endfunction

  function automatic step_row_t pair_row(input logic [11:0] left, input logic [11:0] right);
    step_row_t s;
    s = '0;
    s.kind = ROW_ITEM;
    s.left = left;
    s.right = right;
    return s;
  endfunction

  function automatic step_row_t checked_row(input logic [11:0] left, input logic [11:0] right,
                                            input logic [SPEED_W-1:0] sl,
                                            input logic [SPEED_W-1:0] sr,
                                            input logic [SERVO_W-1:0] sv, input logic db);
    step_row_t s;
    s = pair_row(left, right);
    s.typed = 1'b1;
    s.want.speed_left = sl;
    s.want.speed_right = sr;
    s.want.servo = sv;
    s.want.dead = db;
    return s;
  endfunction

  function automatic logic tally_mismatch();
    mismatch_count++;
    return mismatch_count <= 10;
  endfunction

  // drop valid and hold until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      REG_GAIN_P:    gain_p_q = value[COEF_W-1:0];
      REG_GAIN_I:    gain_i_q = value[COEF_W-1:0];
      REG_GAIN_D:    gain_d_q = value[COEF_W-1:0];
      REG_DECAY:     decay_q = value[DECAY_W-1:0];
      REG_BIAS:      bias_q = value[BIAS_W-1:0];
      REG_DEADBAND:  band_q = value[BAND_W-1:0];
      REG_ANGLE_DIV: div_q = value[DIV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_pair(input logic [11:0] left, input logic [11:0] right,
                           input logic typed, input drive_t typed_drive);
    int unsigned gap;
    drive_t d;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({right, left});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    d = predict_drive(left, right);
    pending_drives.push_back(typed ? typed_drive : d);
    last_left = left;
    last_right = right;
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = drive_t'({out_tuser, out_tdata});
      if (pending_drives.size() == 0) begin
        if (tally_mismatch())
          $display("unexpected beat: speed_left=%0d speed_right=%0d servo=%0d deadband=%0b",
                   $signed(got.speed_left), $signed(got.speed_right), got.servo, got.dead);
      end else begin
        want = pending_drives.pop_front();
        if (got.speed_left !== want.speed_left || got.speed_right !== want.speed_right ||
            got.servo !== want.servo || got.dead !== want.dead) begin
          if (tally_mismatch())
            $display("mismatch at %0t: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     $realtime, $signed(want.speed_left), $signed(want.speed_right),
                     want.servo, want.dead, $signed(got.speed_left),
                     $signed(got.speed_right), got.servo, got.dead);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("leaky_incremental_pid_balance_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan.push_back(pair_row(12'd0, 12'd0));
    plan.push_back(pair_row(12'd4095, 12'd4095));
    plan.push_back(pair_row(12'd4095, 12'd0));
    plan.push_back(pair_row(12'd0, 12'd4095));
    plan.push_back(pair_row(12'd2048, 12'd2048));
    plan.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(cfg_row(REG_GAIN_P, 16'd0));
    plan.push_back(cfg_row(REG_DECAY, 16'd0));
    plan.push_back(cfg_row(REG_DEADBAND, 16'd0));
    plan.push_back(checked_row(12'd4095, 12'd0, 11'd0, 11'd0, 10'd512, 1'b1));
    plan.push_back(checked_row(12'd0, 12'd4095, 11'd0, 11'd0, 10'd512, 1'b1));
    plan.push_back(cfg_row(REG_GAIN_P, 16'hFFFF));
    plan.push_back(cfg_row(REG_GAIN_I, 16'hFFFF));
    plan.push_back(cfg_row(REG_GAIN_D, 16'hFFFF));
    plan.push_back(cfg_row(REG_BIAS, 16'hF7FF));
    plan.push_back(cfg_row(REG_ANGLE_DIV, 16'hFFE2));
    plan.push_back(pair_row(12'd4095, 12'd0));
    plan.push_back(pair_row(12'd4095, 12'd0));
    plan.push_back(checked_row(12'd4095, 12'd0, 11'd1023, 11'h401, 10'd1023, 1'b0));
    plan.push_back(cfg_row(REG_BIAS, 16'h0800));
    plan.push_back(pair_row(12'd0, 12'd4095));
    plan.push_back(pair_row(12'd0, 12'd4095));
    plan.push_back(checked_row(12'd0, 12'd4095, 11'h401, 11'd1023, 10'd0, 1'b0));
    plan.push_back(cfg_row(REG_GAIN_P, 16'd1024));
    plan.push_back(cfg_row(REG_GAIN_I, 16'd0));
    plan.push_back(cfg_row(REG_GAIN_D, 16'd0));
    plan.push_back(cfg_row(REG_DECAY, 16'd1024));
    plan.push_back(cfg_row(REG_DEADBAND, 16'hFFFF));
    plan.push_back(cfg_row(REG_ANGLE_DIV, 16'd0));
    plan.push_back(pair_row(12'd100, 12'd2148));
    plan.push_back(pair_row(12'd3000, 12'd0));
    plan.push_back(cfg_row(REG_ANGLE_DIV, 16'd1));
    plan.push_back(pair_row(12'd4095, 12'd0));
    plan.push_back(cfg_row(REG_ANGLE_DIV, 16'd31));
    plan.push_back(pair_row(12'd0, 12'd1000));
    plan.push_back(pair_row(12'd0, 12'd4095));
    plan.push_back(cfg_row(REG_DECAY, 16'h07FF));
    plan.push_back(pair_row(12'd2500, 12'd0));
    plan.push_back(pair_row(12'd2500, 12'd0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_setting(plan[i].addr, plan[i].value);
      end else begin
        send_pair(plan[i].left, plan[i].right, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      for (int idx = REG_GAIN_P; idx <= REG_ANGLE_DIV; idx++)
        if (ph == 0 || $urandom_range(0, 1) == 1)
          write_setting(CFG_ADDR_W'(idx), pick_setting(reg_idx_t'(idx)));
      if ($urandom_range(0, 3) == 0)
        write_setting(REG_UNUSED, CFG_DATA_W'($urandom));
      calm = (ph % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 59) == 0) drain_results();
        case ($urandom_range(0, 9))
          0: begin
            pick_l = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            pick_r = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          end
          1, 2, 3: begin
            // hover around balance so the deadband gets hit
            pick_l = 12'($urandom);
            pick_r = 12'(int'(pick_l) - int'($signed(bias_q)) + $urandom_range(0, 12) - 6);
          end
          4, 5: begin
            pick_l = last_left + 12'($urandom_range(0, 16)) - 12'd8;
            pick_r = last_right + 12'($urandom_range(0, 16)) - 12'd8;
          end
          default: begin
            pick_l = 12'($urandom);
            pick_r = 12'($urandom);
          end
        endcase
        send_pair(pick_l, pick_r, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += pending_drives.size();
    if (mismatch_count == 0)
      $display("leaky_incremental_pid_balance_tb: clean");
    else
      $display("leaky_incremental_pid_balance_tb: errors");
    $finish;
  end

endmodule
